FILE: hdl/apd_pkg.sv
// Package for the 1-D average pooling block: field widths, register codes
// and the record that travels down the divider chain. No dependencies.
package apd_pkg;

    localparam int MAX_KERNEL = 64;
    localparam int MAX_ROW    = 4096;
    localparam int SAMPLE_W   = 16;

    localparam int KLEN_W = 7;
    localparam int STEP_W = 8;
    localparam int ROW_W  = 13;
    localparam int POS_W  = 12;
    localparam int CFG_W  = ROW_W;

    // A window length changed in mid-row leaves stale terms in the running sum.
    // A row adds at most MAX_ROW samples and removes at most MAX_ROW, so the sum
    // is sized for both and never wraps.
    localparam int SUM_W      = SAMPLE_W + $clog2(MAX_ROW) + 1;
    localparam int DIV_STAGES = SUM_W;

    typedef enum logic [1:0] {
        CFG_KERNEL_LEN = 2'd0,
        CFG_STEP_SIZE  = 2'd1,
        CFG_ROW_LENGTH = 2'd2
    } cfg_index_t;

    // One window on its way through the restoring divider.
    typedef struct packed {
        logic              valid;
        logic [KLEN_W-1:0] rem;
        logic [SUM_W-1:0]  word;   // dividend bits on entry, quotient bits on exit
        logic              neg;
        logic [KLEN_W-1:0] k;
        logic [POS_W-1:0]  idx;
        logic              done;
    } div_stage_t;

endpackage

FILE: hdl/apd_tap_cell.sv
// One cell of the sample delay line: holds one sample and hands it to the
// next cell on every accepted sample. Depends on apd_pkg.
module apd_tap_cell
    import apd_pkg::*;
(
    input  logic                       clk,
    input  logic                       shift_en,
    input  logic                       hit,
    input  logic signed [SAMPLE_W-1:0] d,
    output logic signed [SAMPLE_W-1:0] q,
    output logic signed [SAMPLE_W-1:0] tap
);

    logic signed [SAMPLE_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= d;
        end
    end

    assign q   = data_reg;
    // Only the selected cell passes its value to its tap; the others give zero to the OR.
    assign tap = hit ? data_reg : '0;

endmodule

FILE: hdl/apd_tap_line.sv
// Delay line of MAX_KERNEL tap cells; returns the sample that is kernel_len
// samples old. Depends on apd_pkg and apd_tap_cell.
module apd_tap_line
    import apd_pkg::*;
(
    input  logic                       clk,
    input  logic                       shift_en,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [KLEN_W-1:0]          k_eff,
    output logic signed [SAMPLE_W-1:0] old_sample
);

    logic signed [SAMPLE_W-1:0] link [MAX_KERNEL+1];
    logic signed [SAMPLE_W-1:0] taps [MAX_KERNEL];
    logic [MAX_KERNEL-1:0]      hit;
    logic [KLEN_W-1:0]          sel;

    assign sel     = k_eff - KLEN_W'(1);
    assign link[0] = sample_in;

    always_comb
    begin
        for (int i = 0; i < MAX_KERNEL; i++)
        begin
            hit[i] = (KLEN_W'(i) == sel);
        end
    end

    for (genvar g = 0; g < MAX_KERNEL; g++)
    begin : g_cell
        apd_tap_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .hit      (hit[g]),
            .d        (link[g]),
            .q        (link[g+1]),
            .tap      (taps[g])
        );
    end

    always_comb
    begin
        old_sample = '0;
        for (int i = 0; i < MAX_KERNEL; i++)
        begin
            old_sample = old_sample | taps[i];
        end
    end

endmodule

FILE: hdl/apd_div_cell.sv
// One step of the restoring divider: brings down one dividend bit and
// produces one quotient bit. Depends on apd_pkg.
module apd_div_cell
    import apd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  div_stage_t d,
    output div_stage_t q
);

    logic              valid_reg;
    div_stage_t        data_reg;
    div_stage_t        data_next;
    logic [KLEN_W:0]   shifted;
    logic              ge;

    always_comb
    begin
        shifted   = {d.rem, d.word[SUM_W-1]};
        ge        = (shifted >= {1'b0, d.k});
        data_next = d;
        data_next.rem  = ge ? KLEN_W'(shifted - {1'b0, d.k}) : shifted[KLEN_W-1:0];
        data_next.word = {d.word[SUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        q       = data_reg;
        q.valid = valid_reg;
    end

endmodule

FILE: hdl/apd_divider.sv
// Chain of divider cells plus the output register with sign restore and
// saturation. Depends on apd_pkg and apd_div_cell.
module apd_divider
    import apd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  div_stage_t                 entry,
    output logic                       entry_ready,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] mean,
    output logic [POS_W-1:0]           out_index,
    output logic                       row_done
);

    localparam logic [SUM_W-1:0] POS_LIMIT = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic [SUM_W-1:0] NEG_LIMIT = SUM_W'(1 << (SAMPLE_W - 1));

    div_stage_t             stage [DIV_STAGES+1];
    logic [DIV_STAGES:0]    ready;

    logic                       valid_reg;
    logic signed [SAMPLE_W-1:0] mean_reg;
    logic signed [SAMPLE_W-1:0] mean_next;
    logic [POS_W-1:0]           index_reg;
    logic                       done_reg;
    div_stage_t                 tail;

    assign stage[0] = entry;
    assign tail     = stage[DIV_STAGES];

    // A stage takes new data when it is empty or its content moves on.
    always_comb
    begin
        ready[DIV_STAGES] = !valid_reg || !out_stall;
        for (int i = DIV_STAGES - 1; i >= 0; i--)
        begin
            ready[i] = !stage[i+1].valid || ready[i+1];
        end
    end
    assign entry_ready = ready[0];

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        apd_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .load  (ready[g]),
            .d     (stage[g]),
            .q     (stage[g+1])
        );
    end

    always_comb
    begin
        if (tail.neg)
        begin
            mean_next = (tail.word > NEG_LIMIT) ? signed'(NEG_LIMIT[SAMPLE_W-1:0])
                      : signed'(SAMPLE_W'(0) - tail.word[SAMPLE_W-1:0]);
        end
        else
        begin
            mean_next = (tail.word > POS_LIMIT) ? signed'(POS_LIMIT[SAMPLE_W-1:0])
                      : signed'(tail.word[SAMPLE_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready[DIV_STAGES])
        begin
            valid_reg <= tail.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[DIV_STAGES])
        begin
            mean_reg  <= mean_next;
            index_reg <= tail.idx;
            done_reg  <= tail.done;
        end
    end

    assign out_valid = valid_reg;
    assign mean      = mean_reg;
    assign out_index = index_reg;
    assign row_done  = done_reg;

endmodule

FILE: hdl/avg_pool1d_forward.sv
// Top level of the 1-D average pooling block: configuration registers, row
// bookkeeping and the running window sum. Depends on apd_pkg, apd_tap_line, apd_divider.
//
//   Channel   Handshake           Payload
//   -------   ------------------  --------------------------------
//   input     in_valid/in_stall   sample
//   output    out_valid/out_stall mean, out_index, row_done
//   config    cfg_we              cfg_index, cfg_data
//
// One sample transaction is taken per clock cycle while the output side drains.
// A result passes through the 29 divider cells, one bit of the quotient per divider
// cell, and then through the output register.
// Reset clears the configuration to its defaults and the row state to the start
// of a row; the sample delay line needs no clearing.
// A stalled output fills the divider chain bubble by bubble before in_stall rises.
module avg_pool1d_forward
    import apd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] mean,
    output logic [POS_W-1:0]           out_index,
    output logic                       row_done
);

    // Configuration registers.
    logic [KLEN_W-1:0] kernel_len_reg;
    logic [STEP_W-1:0] step_size_reg;
    logic [ROW_W-1:0]  row_length_reg;

    // Row state.
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic [POS_W-1:0]        pos_reg;
    logic [STEP_W-1:0]       stride_reg;
    logic [STEP_W-1:0]       stride_next;
    logic [POS_W-1:0]        outpos_reg;

    logic [KLEN_W-1:0] k_eff;
    logic [STEP_W-1:0] st_eff;
    logic [ROW_W-1:0]  rl_eff;

    logic                       accept;
    logic                       entry_ready;
    logic signed [SAMPLE_W-1:0] old_sample;
    logic [ROW_W-1:0]           pos_ext;
    logic [ROW_W-1:0]           pos_plus1;
    logic                       last;
    logic                       drop_old;
    logic                       full;
    logic                       emit;
    logic                       done;
    logic [STEP_W:0]            stride_inc;
    logic [SUM_W-1:0]           sum_mag;
    div_stage_t                 entry;

    // Out-of-range register values are pulled into the legal range here.
    always_comb
    begin
        if (kernel_len_reg == '0)
        begin
            k_eff = KLEN_W'(1);
        end
        else if (kernel_len_reg > KLEN_W'(MAX_KERNEL))
        begin
            k_eff = KLEN_W'(MAX_KERNEL);
        end
        else
        begin
            k_eff = kernel_len_reg;
        end

        st_eff = (step_size_reg == '0) ? STEP_W'(1) : step_size_reg;

        if (row_length_reg == '0)
        begin
            rl_eff = ROW_W'(1);
        end
        else if (row_length_reg > ROW_W'(MAX_ROW))
        begin
            rl_eff = ROW_W'(MAX_ROW);
        end
        else
        begin
            rl_eff = row_length_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_len_reg <= KLEN_W'(2);
            step_size_reg  <= STEP_W'(2);
            row_length_reg <= ROW_W'(MAX_ROW);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KERNEL_LEN: kernel_len_reg <= cfg_data[KLEN_W-1:0];
                CFG_STEP_SIZE:  step_size_reg  <= cfg_data[STEP_W-1:0];
                CFG_ROW_LENGTH: row_length_reg <= cfg_data[ROW_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall = !entry_ready;
    assign accept   = in_valid && entry_ready;

    // The delay line keeps the most recent samples; the selected tap is the
    // sample that leaves the window when this one enters.
    apd_tap_line u_taps (
        .clk        (clk),
        .shift_en   (accept),
        .sample_in  (sample),
        .k_eff      (k_eff),
        .old_sample (old_sample)
    );

    always_comb
    begin
        pos_ext   = {1'b0, pos_reg};
        pos_plus1 = pos_ext + ROW_W'(1);
        last      = (pos_plus1 >= rl_eff);
        drop_old  = (pos_ext >= ROW_W'(k_eff));
        full      = (pos_plus1 >= ROW_W'(k_eff));
        emit      = full && (stride_reg == '0);
        done      = last || ((pos_ext + ROW_W'(st_eff)) >= rl_eff);

        sum_next = sum_reg + SUM_W'(sample);
        if (drop_old)
        begin
            sum_next = sum_next - SUM_W'(old_sample);
        end

        // The stride counter wraps when it reaches the step size.
        stride_inc  = {1'b0, stride_reg} + (STEP_W+1)'(1);
        stride_next = (stride_inc >= {1'b0, st_eff}) ? '0 : stride_inc[STEP_W-1:0];

        // The divider works on the magnitude; the sign is restored at its end.
        sum_mag = sum_next[SUM_W-1] ? (SUM_W'(0) - unsigned'(sum_next)) : unsigned'(sum_next);

        entry.valid = accept && emit;
        entry.rem   = '0;
        entry.word  = sum_mag;
        entry.neg   = sum_next[SUM_W-1];
        entry.k     = k_eff;
        entry.idx   = outpos_reg;
        entry.done  = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            pos_reg    <= '0;
            stride_reg <= '0;
            outpos_reg <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                // The row is finished: the window starts over with the next sample.
                sum_reg    <= '0;
                pos_reg    <= '0;
                stride_reg <= '0;
                outpos_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_next;
                pos_reg <= pos_plus1[POS_W-1:0];
                if (full)
                begin
                    stride_reg <= stride_next;
                end
                if (emit)
                begin
                    outpos_reg <= outpos_reg + POS_W'(1);
                end
            end
        end
    end

    apd_divider u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry       (entry),
        .entry_ready (entry_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .mean        (mean),
        .out_index   (out_index),
        .row_done    (row_done)
    );

endmodule

FILE: tb/sv/avg_pool1d_forward_test.sv
// Self-checking testbench for the 1-D average pooling block avg_pool1d_forward.
// Depends on apd_pkg and the RTL of the block; it needs no other files.
// Directed rows come first, then register settings with random samples.

module avg_pool1d_forward_test;

    timeunit 1ns;
    timeprecision 1ps;

    import apd_pkg::*;

    // Results trail their samples through the divider chain. A few spare cycles cover
    // samples that produce no result but are still moving through the block.
    localparam int DRAIN_CYCLES   = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int FULL_SCALE     = (1 << (SAMPLE_W - 1)) - 1;

    // Index 3 has no register behind it; writes to it must change nothing.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One pooled result as it leaves the output channel.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean;
        logic [POS_W-1:0]           index;
        logic                       done;
    } pooled_t;

    // How a directed row is checked: by the predictor, or against a value
    // that is typed into the table (a result, or the absence of one).
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_SILENT,
        ROW_RESULT
    } row_kind_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        row_kind_t                  kind;
        pooled_t                    want;
    } directed_row_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [1:0]                 cfg_index = 2'd0;
    logic [CFG_W-1:0]           cfg_data  = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample    = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] mean;
    logic [POS_W-1:0]           out_index;
    logic                       row_done;

    // Shadow copy of the registers, at their reset values.
    logic [KLEN_W-1:0] kernel_len_q = KLEN_W'(2);
    logic [STEP_W-1:0] step_q       = STEP_W'(2);
    logic [ROW_W-1:0]  row_len_q    = ROW_W'(MAX_ROW);

    // Shadow copy of the window state. Ring entries are only ever read after
    // they were written in the same row, so they need no reset value.
    logic signed [SAMPLE_W-1:0] ring_q [MAX_KERNEL];
    longint                     sum_q     = 0;
    int unsigned                row_pos_q = 0;
    int unsigned                stride_q  = 0;
    int unsigned                out_pos_q = 0;

    pooled_t expected_means [$];

    int idle_pct       = 0;
    int stall_pct      = 0;
    int errors         = 0;
    int samples_taken  = 0;
    int results_seen   = 0;
    int settings_used  = 0;
    int quiet_cycles   = 0;

    // With the reset settings (window 2, step 2, row 4096) every second sample
    // closes a window, so the first results can be worked out by hand. The
    // extremes saturate nothing here; -1 / 2 and -3 / 2 show truncation
    // toward zero. The alternating bit patterns are left to the predictor.
    directed_row_t directed_rows [14] = '{
        '{16'sh7FFF, ROW_SILENT,  '{16'sh0000, 12'd0, 1'b0}},
        '{16'sh7FFF, ROW_RESULT,  '{16'sh7FFF, 12'd0, 1'b0}},
        '{16'sh8000, ROW_SILENT,  '{16'sh0000, 12'd0, 1'b0}},
        '{16'sh8000, ROW_RESULT,  '{16'sh8000, 12'd1, 1'b0}},
        '{16'sh0001, ROW_SILENT,  '{16'sh0000, 12'd0, 1'b0}},
        '{16'shFFFE, ROW_RESULT,  '{16'sh0000, 12'd2, 1'b0}},
        '{16'shFFFF, ROW_SILENT,  '{16'sh0000, 12'd0, 1'b0}},
        '{16'shFFFE, ROW_RESULT,  '{16'shFFFF, 12'd3, 1'b0}},
        '{16'sh5555, ROW_PREDICT, '{16'sh0000, 12'd0, 1'b0}},
        '{16'shAAAA, ROW_PREDICT, '{16'sh0000, 12'd0, 1'b0}},
        '{16'sh0000, ROW_PREDICT, '{16'sh0000, 12'd0, 1'b0}},
        '{16'sh7FFF, ROW_PREDICT, '{16'sh0000, 12'd0, 1'b0}},
        '{16'sh8000, ROW_PREDICT, '{16'sh0000, 12'd0, 1'b0}},
        '{16'sh7FFF, ROW_PREDICT, '{16'sh0000, 12'd0, 1'b0}}
    };

    avg_pool1d_forward dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mean      (mean),
        .out_index (out_index),
        .row_done  (row_done)
    );

    always #5 clk = ~clk;

    // Pools one accepted sample into the shadow window and returns 1 with
    // the expected result when that sample completes a window on the stride.
    function automatic bit pool_sample(input logic signed [SAMPLE_W-1:0] x,
                                       output pooled_t res);
        int unsigned k;
        int unsigned st;
        int unsigned rl;
        int unsigned pos;
        longint      avg;
        bit          last;
        bit          hit;
        // Register values out of range are clamped the same way the block does.
        k   = (kernel_len_q == 0) ? 1 :
              (kernel_len_q > MAX_KERNEL) ? MAX_KERNEL : kernel_len_q;
        st  = (step_q == 0) ? 1 : step_q;
        rl  = (row_len_q == 0) ? 1 : (row_len_q > MAX_ROW) ? MAX_ROW : row_len_q;
        pos = row_pos_q;
        res = '0;
        hit = 1'b0;
        // A row shrunk below the current position ends at this sample.
        last = (pos + 1 >= rl);
        if (pos >= k)
            sum_q -= ring_q[(pos - k) % MAX_KERNEL];
        ring_q[pos % MAX_KERNEL] = x;
        sum_q += x;
        if (pos + 1 >= k)
        begin
            if (stride_q == 0)
            begin
                // Signed division truncates toward zero. Only a window that
                // shrank in mid-row can push the mean past full scale.
                avg = sum_q / longint'(k);
                if (avg > FULL_SCALE)
                    avg = FULL_SCALE;
                if (avg < -FULL_SCALE - 1)
                    avg = -FULL_SCALE - 1;
                res.mean  = avg[SAMPLE_W-1:0];
                res.index = out_pos_q[POS_W-1:0];
                res.done  = last || (pos + st >= rl);
                out_pos_q = (out_pos_q + 1) % (1 << POS_W);
                hit = 1'b1;
            end
            // A count left above a smaller new step wraps on this advance.
            if (stride_q + 1 >= st)
                stride_q = 0;
            else
                stride_q++;
        end
        if (last)
        begin
            sum_q     = 0;
            row_pos_q = 0;
            stride_q  = 0;
            out_pos_q = 0;
        end
        else
        begin
            row_pos_q = pos + 1;
        end
        return hit;
    endfunction

    // Mostly uniform samples, with the two extremes showing up now and then.
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        if ($urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        return SAMPLE_W'($urandom);
    endfunction

    function automatic void set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin idle_pct = 55; stall_pct = 0;  end
            IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 55; end
            default:       begin idle_pct = 36; stall_pct = 36; end
        endcase
    endfunction

    // Offers one sample transaction and returns at the edge that accepts it.
    // A random gap may come first; valid only drops when a gap is taken, so
    // back-to-back transactions keep valid high without a glitch.
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] value);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do
            @(posedge clk);
        while (in_stall);
        samples_taken++;
    endtask

    task automatic feed_sample(input logic signed [SAMPLE_W-1:0] value);
        pooled_t res;
        push_sample(value);
        if (pool_sample(value, res))
            expected_means.push_back(res);
    endtask

    // Holds the input off until every expected mean has come out, then lets
    // the pipeline run empty so that silent samples have left it too.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_means.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Writes all three registers on consecutive edges, then a stray write to
    // the unused index. Only called while the block is idle.
    task automatic write_config(input logic [CFG_W-1:0] klen_word,
                                input logic [CFG_W-1:0] step_word,
                                input logic [CFG_W-1:0] row_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_KERNEL_LEN;
        cfg_data  <= klen_word;
        @(posedge clk);
        kernel_len_q = klen_word[KLEN_W-1:0];
        cfg_index <= CFG_STEP_SIZE;
        cfg_data  <= step_word;
        @(posedge clk);
        step_q = step_word[STEP_W-1:0];
        cfg_index <= CFG_ROW_LENGTH;
        cfg_data  <= row_word;
        @(posedge clk);
        row_len_q = row_word[ROW_W-1:0];
        cfg_index <= CFG_SPARE;
        cfg_data  <= CFG_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Brings the row state back to its start. A row in progress is cut off
    // by shrinking the row length to one, so the next sample ends it.
    task automatic end_row();
        settle();
        if (row_pos_q != 0)
        begin
            write_config(CFG_W'(kernel_len_q), CFG_W'(step_q), CFG_W'(1));
            feed_sample(rand_sample());
            settle();
        end
    endtask

    // The receiver stalls at random, independently of the sender.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // Every accepted result transaction is held against the oldest expected
    // mean; each field that differs counts as one failure of its own.
    always @(posedge clk)
    begin : result_check
        pooled_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_means.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual mean %0d index %0d done %0b",
                         $time, mean, out_index, row_done);
            end
            else
            begin
                want = expected_means.pop_front();
                if (mean !== want.mean)
                begin
                    errors++;
                    $display("%0t: mean mismatch, expected %0d, actual %0d",
                             $time, want.mean, mean);
                end
                if (out_index !== want.index)
                begin
                    errors++;
                    $display("%0t: out_index mismatch, expected %0d, actual %0d",
                             $time, want.index, out_index);
                end
                if (row_done !== want.done)
                begin
                    errors++;
                    $display("%0t: row_done mismatch, expected %0b, actual %0b",
                             $time, want.done, row_done);
                end
            end
        end
    end

    // The watchdog ends a run in which no transaction moves for too long,
    // which also catches results that never arrive.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results still expected",
                     $time, WATCHDOG_LIMIT, expected_means.size());
            $display("avg_pool1d_forward verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        pooled_t     res;
        bit          hit;
        int unsigned r;
        int unsigned kv;
        int unsigned sv;
        int unsigned rv;
        int unsigned n;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows under the reset settings, back to back.
        set_idling(IDLE_NONE);
        foreach (directed_rows[i])
        begin
            push_sample(directed_rows[i].value);
            hit = pool_sample(directed_rows[i].value, res);
            if (directed_rows[i].kind == ROW_RESULT)
                expected_means.push_back(directed_rows[i].want);
            else if (directed_rows[i].kind == ROW_PREDICT && hit)
                expected_means.push_back(res);
        end
        settle();

        // Zero in every register reads as one. The row is already past
        // position five, so the next sample cuts it off.
        set_idling(IDLE_SENDER);
        write_config(CFG_W'(0), CFG_W'(0), CFG_W'(0));
        write_config(CFG_W'(0), CFG_W'(0), CFG_W'(5));
        repeat (30)
            feed_sample(rand_sample());
        end_row();

        // Oversized window and row clamp to their maximum sizes.
        set_idling(IDLE_RECEIVER);
        write_config(CFG_W'(127), CFG_W'(1), CFG_W'(8191));
        repeat (100)
            feed_sample(rand_sample());
        end_row();

        // A full window of near full-scale samples, then the window shrinks
        // in mid-row: the stale sum divided by the new length saturates.
        set_idling(IDLE_BOTH);
        write_config(CFG_W'(MAX_KERNEL), CFG_W'(1), CFG_W'(300));
        repeat (80)
            feed_sample(SAMPLE_W'(16'sh7FFF - $urandom_range(0, 3)));
        settle();
        write_config(CFG_W'(1), CFG_W'(1), CFG_W'(300));
        repeat (16)
            feed_sample(SAMPLE_W'(16'sh7FFF - $urandom_range(0, 3)));
        end_row();
        write_config(CFG_W'(MAX_KERNEL), CFG_W'(1), CFG_W'(300));
        repeat (80)
            feed_sample(SAMPLE_W'(16'sh8000 + $urandom_range(0, 3)));
        settle();
        write_config(CFG_W'(3), CFG_W'(1), CFG_W'(300));
        repeat (16)
            feed_sample(SAMPLE_W'(16'sh8000 + $urandom_range(0, 3)));
        end_row();

        // The largest step, then a smaller one in mid-row: the stride count
        // is already above the new step and has to wrap.
        set_idling(IDLE_SENDER);
        write_config(CFG_W'(1), CFG_W'(255), CFG_W'(MAX_ROW));
        repeat (10)
            feed_sample(rand_sample());
        settle();
        write_config(CFG_W'(1), CFG_W'(3), CFG_W'(MAX_ROW));
        repeat (20)
            feed_sample(rand_sample());
        end_row();

        // A row with a mean per sample ends on its own at its last sample.
        set_idling(IDLE_NONE);
        write_config(CFG_W'(1), CFG_W'(1), CFG_W'(100));
        repeat (100)
            feed_sample(rand_sample());

        // Random settings, mostly small windows and short rows so that many
        // rows complete; now and then a zero, a clamped value, or a row too
        // short for the window. Unused upper data bits carry noise.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            end_row();
            r = $urandom_range(0, 99);
            if (r < 70)
                kv = $urandom_range(1, 8);
            else if (r < 85)
                kv = $urandom_range(9, MAX_KERNEL);
            else if (r < 92)
                kv = 0;
            else
                kv = $urandom_range(MAX_KERNEL + 1, 127);
            r = $urandom_range(0, 99);
            if (r < 75)
                sv = $urandom_range(1, 6);
            else if (r < 90)
                sv = $urandom_range(7, 255);
            else
                sv = 0;
            r = $urandom_range(0, 99);
            if (r < 55)
                rv = $urandom_range(1, 48);
            else if (r < 75)
                rv = $urandom_range(1, (kv > 1) ? kv : 1);
            else if (r < 85)
                rv = 0;
            else
                rv = $urandom_range(MAX_ROW + 1, 8191);
            write_config(CFG_W'(kv | ($urandom_range(0, 63) << KLEN_W)),
                         CFG_W'(sv | ($urandom_range(0, 31) << STEP_W)),
                         CFG_W'(rv));
            set_idling(idle_mode_t'(p % 4));
            n = $urandom_range(25, 55);
            repeat (n)
                feed_sample(rand_sample());
        end
        settle();

        $display("Summary: %0d sample and %0d result transactions over %0d register settings.",
                 samples_taken, results_seen, settings_used);
        $display("Summary: idle mixes none to 55%%, saturation, stride wrap and row cut-off.");
        if (errors == 0)
            $display("avg_pool1d_forward verification clean");
        else
            $display("avg_pool1d_forward verification failed");
        $finish;
    end

endmodule
